// File: sv/assert_macros.svh
// Assertion helpers used by the CRC checker.
// Each macro takes a label, a clock, an active-low reset, an antecedent
// and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RCRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcrc assertion failed");

// Next-cycle implication.
`define RCRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcrc assertion failed");

`endif

// File: sv/rcrc_pkg.sv
// ---------------------------------------------------------------------------
// rcrc_pkg
// Shared constants and types of the reflected CRC generator and checker.
// ---------------------------------------------------------------------------
`default_nettype none

package rcrc_pkg;

    localparam int MAX_CRC_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int MSG_W      = 16;
    localparam int CW_W       = 6;
    localparam int EW_W       = 7;
    localparam int CNT_W      = 17;

    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_POLY      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_WIDTH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_BITS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK     = 8'd3;

    // Register values after reset.
    localparam logic [31:0]      RST_POLY      = 32'h04C11DB7;
    localparam logic [CW_W-1:0]  RST_CRC_WIDTH = 6'd32;
    localparam logic [MSG_W-1:0] RST_MSG_BITS  = 16'd1024;
    localparam logic             RST_CHECK     = 1'b0;

    // Decoded configuration handed to the datapath.
    typedef struct packed {
        logic [MSG_W-1:0] msg_bits;
        logic [EW_W-1:0]  width;
        logic             check;
    } t_cfg;

endpackage

`default_nettype wire

// File: sv/rcrc_ifs.sv
// ---------------------------------------------------------------------------
// rcrc interfaces
// Valid/ready channels for frame bytes, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface rcrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rcrc_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;
    logic        crc_ok;
    logic        short_frame;

    modport source (output valid, output crc_value, output crc_ok, output short_frame,
                    input ready);
    modport sink   (input valid, input crc_value, input crc_ok, input short_frame,
                    output ready);
endinterface

interface rcrc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rcrc_pkg::CFG_IDX_W-1:0]   index;
    logic [rcrc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/rcrc_cfg.sv
// ---------------------------------------------------------------------------
// rcrc_cfg
// Configuration registers, with the effective width and the reflected
// polynomial worked out when a register is written.
// ---------------------------------------------------------------------------
`default_nettype none

module rcrc_cfg #(
    parameter int MAX_CRC_WIDTH = rcrc_pkg::MAX_CRC_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    rcrc_cfg_if.sink                       i_cfg,
    output rcrc_pkg::t_cfg                 o_cfg,
    output logic [MAX_CRC_WIDTH-1:0]       o_rev
);

    function automatic logic [rcrc_pkg::EW_W-1:0] eff_width(
        input logic [rcrc_pkg::CW_W-1:0] cw
    );
        logic [rcrc_pkg::EW_W-1:0] w;
        w = {1'b0, cw};
        if (cw == '0) begin
            w = rcrc_pkg::EW_W'(1);
        end else if (w > rcrc_pkg::EW_W'(MAX_CRC_WIDTH)) begin
            w = rcrc_pkg::EW_W'(MAX_CRC_WIDTH);
        end
        return w;
    endfunction

    // Reverse the low w bits of the polynomial: reverse across the full
    // register, then drop the positions above the width.
    function automatic logic [MAX_CRC_WIDTH-1:0] rev_poly(
        input logic [31:0]                poly,
        input logic [rcrc_pkg::EW_W-1:0]  w
    );
        logic [MAX_CRC_WIDTH-1:0]  full;
        logic [rcrc_pkg::EW_W-1:0] sh;
        full = '0;
        for (int j = 0; j < MAX_CRC_WIDTH; j++) begin
            if (j < 32) begin
                full[MAX_CRC_WIDTH-1-j] = poly[j];
            end
        end
        sh = rcrc_pkg::EW_W'(MAX_CRC_WIDTH) - w;
        return full >> sh;
    endfunction

    logic [31:0]                   r_poly, n_poly;
    logic [rcrc_pkg::CW_W-1:0]     r_cw, n_cw;
    logic [rcrc_pkg::MSG_W-1:0]    r_msg, n_msg;
    logic                          r_chk, n_chk;
    logic [rcrc_pkg::EW_W-1:0]     r_eff;
    logic [MAX_CRC_WIDTH-1:0]      r_rev;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_poly = r_poly;
        n_cw   = r_cw;
        n_msg  = r_msg;
        n_chk  = r_chk;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                rcrc_pkg::CFG_POLY:      n_poly = i_cfg.data;
                rcrc_pkg::CFG_CRC_WIDTH: n_cw   = i_cfg.data[rcrc_pkg::CW_W-1:0];
                rcrc_pkg::CFG_MSG_BITS:  n_msg  = i_cfg.data[rcrc_pkg::MSG_W-1:0];
                rcrc_pkg::CFG_CHECK:     n_chk  = i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= rcrc_pkg::RST_POLY;
            r_cw   <= rcrc_pkg::RST_CRC_WIDTH;
            r_msg  <= rcrc_pkg::RST_MSG_BITS;
            r_chk  <= rcrc_pkg::RST_CHECK;
            r_eff  <= eff_width(rcrc_pkg::RST_CRC_WIDTH);
            r_rev  <= rev_poly(rcrc_pkg::RST_POLY, eff_width(rcrc_pkg::RST_CRC_WIDTH));
        end else begin
            r_poly <= n_poly;
            r_cw   <= n_cw;
            r_msg  <= n_msg;
            r_chk  <= n_chk;
            r_eff  <= eff_width(n_cw);
            r_rev  <= rev_poly(n_poly, eff_width(n_cw));
        end
    end

    assign o_cfg.msg_bits = r_msg;
    assign o_cfg.width    = r_eff;
    assign o_cfg.check    = r_chk;
    assign o_rev          = r_rev;

endmodule

`default_nettype wire

// File: sv/rcrc_byte_upd.sv
// ---------------------------------------------------------------------------
// rcrc_byte_upd
// Eight-bit update of the running CRC, the frame bit count and the
// gathered received CRC for one byte.
// ---------------------------------------------------------------------------
`default_nettype none

module rcrc_byte_upd #(
    parameter int MAX_CRC_WIDTH = rcrc_pkg::MAX_CRC_WIDTH_DEF
) (
    input  wire rcrc_pkg::t_cfg              i_cfg,
    input  wire logic [MAX_CRC_WIDTH-1:0]    i_rev,
    input  wire logic [MAX_CRC_WIDTH-1:0]    i_crc,
    input  wire logic [rcrc_pkg::CNT_W-1:0]  i_cnt,
    input  wire logic [MAX_CRC_WIDTH-1:0]    i_recv,
    input  wire logic [7:0]                  i_data,
    output logic [MAX_CRC_WIDTH-1:0]         o_crc,
    output logic [rcrc_pkg::CNT_W-1:0]       o_cnt,
    output logic [MAX_CRC_WIDTH-1:0]         o_recv
);

    localparam int IW = $clog2(MAX_CRC_WIDTH);
    localparam int PW = rcrc_pkg::CNT_W + 1;

    logic [MAX_CRC_WIDTH-1:0] c;
    logic [MAX_CRC_WIDTH-1:0] r;
    logic [PW-1:0]            p;
    logic [PW-1:0]            pos;
    logic [PW-1:0]            crc_end;
    logic [PW-1:0]            msg_ext;
    logic [PW-1:0]            cnt_sum;
    logic                     fb;

    always_comb begin
        c       = i_crc;
        r       = i_recv;
        msg_ext = PW'(i_cfg.msg_bits);
        crc_end = msg_ext + PW'(i_cfg.width);
        for (int i = 0; i < 8; i++) begin
            p   = {1'b0, i_cnt} + PW'(i);
            pos = p - msg_ext;
            fb  = c[0] ^ i_data[i];
            if (p < msg_ext) begin
                c = (c >> 1) ^ (fb ? i_rev : '0);
            end else if (i_cfg.check && (p < crc_end)) begin
                r[pos[IW-1:0]] = r[pos[IW-1:0]] | i_data[i];
            end
        end
        o_crc  = c;
        o_recv = r;
    end

    // Bit count saturates at its maximum.
    assign cnt_sum = {1'b0, i_cnt} + PW'(8);
    assign o_cnt   = (cnt_sum > {1'b0, rcrc_pkg::COUNT_MAX}) ? rcrc_pkg::COUNT_MAX
                                                             : cnt_sum[rcrc_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

// File: sv/reflected_crc_generate_check.sv
// ---------------------------------------------------------------------------
// reflected_crc_generate_check
// Reflected CRC generator and checker with a configurable polynomial.
// ---------------------------------------------------------------------------
// Frame bytes arrive on i_byte, bit 0 of each byte first; last marks the
// final byte of a frame. The first message_bits bits feed a reflected CRC
// (start value zero, no final XOR) whose polynomial is written in normal
// form. In check mode the next crc_width bits are gathered as the received
// CRC. Bits beyond that are ignored.
// One result beat leaves on o_res per frame: the CRC, the match flag and a
// short-frame flag. Register writes come on i_cfg, which is always ready;
// write registers only while no frame is in flight.
// Throughput is one byte per cycle while no last byte waits on a stalled
// result. A byte goes into an input register, then the eight-bit CRC update
// runs into the frame state and, on a last beat, into the result register.
// If the receiver stalls, the result register holds its beat; bytes that
// are not last keep flowing, while a last byte waits in the input register
// and i_byte.ready drops until the pending result is taken.
// Reset clears the frame state and both pipeline valids and restores the
// register defaults (CRC-32 polynomial, width 32, 1024 message bits,
// generate mode).
// ---------------------------------------------------------------------------
`default_nettype none

module reflected_crc_generate_check #(
    parameter int MAX_CRC_WIDTH = rcrc_pkg::MAX_CRC_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcrc_byte_if.sink  i_byte,
    rcrc_res_if.source o_res,
    rcrc_cfg_if.sink   i_cfg
);

    rcrc_pkg::t_cfg                 cfg;
    logic [MAX_CRC_WIDTH-1:0]       rev;

    // Input register.
    logic                           r_s1_vld;
    logic [7:0]                     r_s1_data;
    logic                           r_s1_last;

    // Frame state.
    logic [MAX_CRC_WIDTH-1:0]       r_crc, n_crc;
    logic [rcrc_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [MAX_CRC_WIDTH-1:0]       r_recv, n_recv;

    // Result register.
    logic                           r_out_vld;
    logic [31:0]                    r_out_crc;
    logic                           r_out_ok;
    logic                           r_out_short;

    logic                           advance;
    logic                           in_ready;
    logic [MAX_CRC_WIDTH+31:0]      crc_ext;
    logic [rcrc_pkg::CNT_W-1:0]     needed;

    rcrc_cfg #(
        .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg),
        .o_rev   (rev)
    );

    rcrc_byte_upd #(
        .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
    ) u_upd (
        .i_cfg  (cfg),
        .i_rev  (rev),
        .i_crc  (r_crc),
        .i_cnt  (r_cnt),
        .i_recv (r_recv),
        .i_data (r_s1_data),
        .o_crc  (n_crc),
        .o_cnt  (n_cnt),
        .o_recv (n_recv)
    );

    // The buffered byte moves on unless it closes a frame whose result
    // would overwrite one that is still waiting.
    assign advance  = r_s1_vld && (!r_s1_last || !r_out_vld || o_res.ready);
    assign in_ready = !r_s1_vld || advance;
    assign i_byte.ready = in_ready;

    // The CRC register may be narrower or wider than the 32-bit output.
    assign crc_ext = {32'b0, n_crc};

    // Expected frame length: message bits, plus the CRC bits in check mode.
    assign needed = {1'b0, cfg.msg_bits}
                  + (cfg.check ? rcrc_pkg::CNT_W'(cfg.width) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_crc     <= '0;
            r_cnt     <= '0;
            r_recv    <= '0;
        end else begin
            if (in_ready) begin
                r_s1_vld <= i_byte.valid;
            end
            // A new result replaces the one taken in the same cycle.
            if (advance && r_s1_last) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                if (r_s1_last) begin
                    r_crc     <= '0;
                    r_cnt     <= '0;
                    r_recv    <= '0;
                end else begin
                    r_crc     <= n_crc;
                    r_cnt     <= n_cnt;
                    r_recv    <= n_recv;
                end
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte.valid) begin
            r_s1_data <= i_byte.data_byte;
            r_s1_last <= i_byte.last;
        end
        if (advance && r_s1_last) begin
            r_out_crc   <= crc_ext[31:0];
            r_out_ok    <= cfg.check && (n_crc == n_recv);
            r_out_short <= n_cnt < needed;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.crc_value   = r_out_crc;
    assign o_res.crc_ok      = r_out_ok;
    assign o_res.short_frame = r_out_short;

endmodule

`default_nettype wire

// File: sv/rcrc_checker.sv
// ---------------------------------------------------------------------------
// rcrc_checker
// Port-level checks of the CRC block, attached by a bind statement.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rcrc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_last,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    // Frames whose last beat went in and whose result has not gone out.
    logic [1:0] r_pend;
    logic       last_acc;
    logic       res_acc;

    assign last_acc = i_in_valid && i_in_ready && i_in_last;
    assign res_acc  = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (last_acc && !res_acc) begin
            r_pend <= r_pend + 2'd1;
        end else if (!last_acc && res_acc) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // A stalled result beat stays offered.
    `RCRC_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // With no result blocking the output, the input is never held off.
    `RCRC_ASSERT_IMP(a_in_free, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready)

    // Every result beat belongs to a frame whose last byte was taken.
    `RCRC_ASSERT_IMP(a_res_owed, i_clk, i_rst_n, i_out_valid, r_pend != 2'd0)

    // At most two frames sit between the input and the output.
    `RCRC_ASSERT_IMP(a_pend_max, i_clk, i_rst_n, 1'b1, r_pend != 2'd3)

endmodule

bind reflected_crc_generate_check rcrc_checker u_rcrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_in_last   (i_byte.last),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);

`default_nettype wire
